>>> hw/rtl/uule_pkg.sv
// ----------------------------------------------------------------------------
// uule_pkg
// Shared types, constants and the character mapping for the uuencode line
// encoder.
// ----------------------------------------------------------------------------
package uule_pkg;

    // Default depth of the line buffer in bytes
    localparam int MAX_LINE_BYTES_DEF = 45;

    // Field widths
    localparam int BYTE_W = 8;
    localparam int CHAR_W = 7;
    localparam int LB_W   = 6;
    localparam int SEXT_W = 6;

    // Reset value of the bytes-per-line register
    localparam logic [LB_W-1:0] LINE_BYTES_RESET = 6'd45;

    // Character codes
    localparam logic [CHAR_W-1:0] CHAR_NL       = 7'd10;
    localparam logic [CHAR_W-1:0] CHAR_SPACE    = 7'd32;
    localparam logic [CHAR_W-1:0] CHAR_BACKTICK = 7'd96;

    // Input mode codes
    localparam logic MODE_DATA = 1'b0;
    localparam logic MODE_END  = 1'b1;

    typedef struct packed {
        logic              mode;
        logic [BYTE_W-1:0] data_byte;
    } in_word_t;

    typedef struct packed {
        logic [CHAR_W-1:0] out_char;
        logic              last;
    } out_word_t;

    // Map a six-bit value to its printable character; zero becomes backtick
    function automatic logic [CHAR_W-1:0] enc_char(input logic [SEXT_W-1:0] v);
        logic [CHAR_W-1:0] c;
        c = CHAR_SPACE + {1'b0, v};
        return (v == '0) ? CHAR_BACKTICK : c;
    endfunction

endpackage

>>> hw/rtl/uule_line_mem.sv
// ----------------------------------------------------------------------------
// uule_line_mem
// Line buffer: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module uule_line_mem
    import uule_pkg::*;
#(
    parameter int DEPTH  = MAX_LINE_BYTES_DEF,
    parameter int ADDR_W = $clog2(DEPTH)
)
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [BYTE_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [BYTE_W-1:0] rd_data
);

    logic [BYTE_W-1:0] mem [DEPTH];
    logic [BYTE_W-1:0] rd_data_reg;

    // Store incoming bytes
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Register read data
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> hw/rtl/uuencode_line_encoder.sv
// ----------------------------------------------------------------------------
// uuencode_line_encoder
// Collects raw bytes into a line and sends each finished line as uuencoded
// ASCII characters, one character per output word.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / in_word): a word is a data byte
//   (mode 0) or an end-of-stream mark (mode 1). A data byte that does not
//   complete a line is taken without a stall. A byte that fills the line,
//   or an end mark with bytes held, starts encoding; in_stall stays high
//   until the newline has been loaded into the output register.
//   Output channel (out_valid / out_stall / out_word): length character, four
//   characters per three-byte group, then newline with last set.
//   Sequence: after the closing input word, ST_LEN loads the length
//   character once the output is free. Each group then passes through
//   ST_FETCH (up to three buffer reads, each byte shifted into the shared
//   shifter, zeros past the line end) and ST_EMIT (four 6-bit shifts).
//   A stall on the output holds the output register and stops the sequencer
//   at its next character.
//   cfg_we writes the bytes-per-line register (reset 45); 0 acts as 1 and
//   values above MAX_LINE_BYTES act as MAX_LINE_BYTES.
//   Reset empties the line and the output register; buffer contents are
//   left as they are and never read before being written.
// ----------------------------------------------------------------------------
module uuencode_line_encoder
    import uule_pkg::*;
#(
    parameter int MAX_LINE_BYTES = MAX_LINE_BYTES_DEF
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  in_word_t        in_word,
    output logic            out_valid,
    input  logic            out_stall,
    output out_word_t       out_word,
    input  logic            cfg_we,
    input  logic [LB_W-1:0] cfg_data
);

    localparam int CNT_W  = $clog2(MAX_LINE_BYTES + 1);
    localparam int ADDR_W = $clog2(MAX_LINE_BYTES);
    localparam int POS_W  = CNT_W + 2;
    localparam int GRP_W  = 3 * BYTE_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LEN,
        ST_FETCH,
        ST_EMIT,
        ST_NL
    } state_t;

    state_t            state_reg,     state_next;
    logic [CNT_W-1:0]  fill_reg,      fill_next;
    logic [CNT_W-1:0]  len_reg,       len_next;
    logic [POS_W-1:0]  base_reg,      base_next;
    logic [1:0]        sub_reg,       sub_next;
    logic              pad_reg,       pad_next;
    logic [GRP_W-1:0]  group_reg,     group_next;
    logic              out_valid_reg, out_valid_next;
    out_word_t         out_word_reg,  out_word_next;
    logic [LB_W-1:0]   line_bytes_reg;

    logic              out_free;
    logic [CNT_W-1:0]  limit;
    logic [CNT_W-1:0]  fill_inc;
    logic [POS_W-1:0]  idx;
    logic              idx_in;
    logic              wr_en;
    logic              rd_en;
    logic [BYTE_W-1:0] rd_data;

    // Clamp the line length to 1..MAX_LINE_BYTES
    always_comb
    begin
        if (line_bytes_reg == '0)
        begin
            limit = CNT_W'(1);
        end
        else if (7'(line_bytes_reg) > 7'(MAX_LINE_BYTES))
        begin
            limit = CNT_W'(MAX_LINE_BYTES);
        end
        else
        begin
            limit = CNT_W'(line_bytes_reg);
        end
    end

    assign out_free = !out_valid_reg || !out_stall;
    assign fill_inc = (32'(fill_reg) < MAX_LINE_BYTES) ? fill_reg + 1'b1 : fill_reg;
    assign idx      = base_reg + POS_W'(sub_reg);
    assign idx_in   = idx < POS_W'(len_reg);
    assign wr_en    = (state_reg == ST_IDLE) && in_valid && (in_word.mode == MODE_DATA)
                      && (32'(fill_reg) < MAX_LINE_BYTES);
    assign rd_en    = (state_reg == ST_FETCH) && (sub_reg != 2'd3) && idx_in;

    uule_line_mem #(
        .DEPTH  (MAX_LINE_BYTES),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (ADDR_W'(fill_reg)),
        .wr_data (in_word.data_byte),
        .rd_en   (rd_en),
        .rd_addr (ADDR_W'(idx)),
        .rd_data (rd_data)
    );

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        len_next       = len_reg;
        base_next      = base_reg;
        sub_next       = sub_reg;
        pad_next       = pad_reg;
        group_next     = group_reg;
        out_valid_next = out_valid_reg;
        out_word_next  = out_word_reg;

        // Drop the output word once taken
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_word.mode == MODE_END)
                    begin
                        if (fill_reg != '0)
                        begin
                            len_next   = fill_reg;
                            fill_next  = '0;
                            state_next = ST_LEN;
                        end
                    end
                    else if (fill_inc >= limit)
                    begin
                        len_next   = fill_inc;
                        fill_next  = '0;
                        state_next = ST_LEN;
                    end
                    else
                    begin
                        fill_next = fill_inc;
                    end
                end
            end
            ST_LEN:
            begin
                if (out_free)
                begin
                    out_valid_next         = 1'b1;
                    out_word_next.out_char = enc_char(SEXT_W'(len_reg));
                    out_word_next.last     = 1'b0;
                    base_next              = '0;
                    sub_next               = '0;
                    state_next             = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                // Issue reads for three bytes, shift each one in from the registered read data
                pad_next = !idx_in;
                if (sub_reg != 2'd0)
                begin
                    group_next = {group_reg[GRP_W-BYTE_W-1:0],
                                  pad_reg ? BYTE_W'(0) : rd_data};
                end
                if (sub_reg == 2'd3)
                begin
                    sub_next   = '0;
                    state_next = ST_EMIT;
                end
                else
                begin
                    sub_next = sub_reg + 1'b1;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next         = 1'b1;
                    out_word_next.out_char = enc_char(group_reg[GRP_W-1 -: SEXT_W]);
                    out_word_next.last     = 1'b0;
                    group_next             = group_reg << SEXT_W;
                    if (sub_reg == 2'd3)
                    begin
                        sub_next  = '0;
                        base_next = base_reg + POS_W'(3);
                        if (base_reg + POS_W'(3) >= POS_W'(len_reg))
                        begin
                            state_next = ST_NL;
                        end
                        else
                        begin
                            state_next = ST_FETCH;
                        end
                    end
                    else
                    begin
                        sub_next = sub_reg + 1'b1;
                    end
                end
            end
            ST_NL:
            begin
                if (out_free)
                begin
                    out_valid_next         = 1'b1;
                    out_word_next.out_char = CHAR_NL;
                    out_word_next.last     = 1'b1;
                    state_next             = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            fill_reg       <= '0;
            out_valid_reg  <= 1'b0;
            line_bytes_reg <= LINE_BYTES_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                line_bytes_reg <= cfg_data;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        len_reg      <= len_next;
        base_reg     <= base_next;
        sub_reg      <= sub_next;
        pad_reg      <= pad_next;
        group_reg    <= group_next;
        out_word_reg <= out_word_next;
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

endmodule

>>> hw/rtl/uule_checker.sv
// ----------------------------------------------------------------------------
// uule_checker
// Port-level checks for the uuencode line encoder, bound to the top level.
// ----------------------------------------------------------------------------
module uule_checker
    import uule_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_stall,
    input logic      out_valid,
    input logic      out_stall,
    input out_word_t out_word
);

    // Hold a stalled output word
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_word))
        else $error("stalled output word changed");

    // End a line only with a newline
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_word.last |-> out_word.out_char == CHAR_NL)
        else $error("last word is not a newline");

    // Keep body characters printable
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_word.last |->
            out_word.out_char >= CHAR_SPACE && out_word.out_char <= CHAR_BACKTICK)
        else $error("body character out of range");

    // Keep a stalled input word valid
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid)
        else $error("stalled input word withdrawn");

endmodule

bind uuencode_line_encoder uule_checker u_uule_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
);

>>> tb/uuencode_line_encoder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uuencode_line_encoder_tb
// Drives raw bytes and end-of-stream marks into the line encoder under random
// input gaps and output stalls. Each accepted input word is run through a
// line predictor, and every output character is checked in order against
// the characters that the predictor expects. The bytes-per-line register is
// rewritten between phases, including zero, the maximum and a value below
// the current fill.
// ----------------------------------------------------------------------------
module uuencode_line_encoder_tb;
    import uule_pkg::*;

    localparam int LINE_CAP      = MAX_LINE_BYTES_DEF;
    localparam int SETTLE_CYCLES = 16;
    localparam int TAIL_CYCLES   = 200;
    localparam int CYCLE_LIMIT   = 400000;

    logic            clk       = 1'b0;
    logic            rst_n     = 1'b0;
    logic            in_valid  = 1'b0;
    logic            in_stall;
    in_word_t        in_word   = '0;
    logic            out_valid;
    logic            out_stall = 1'b0;
    out_word_t       out_word;
    logic            cfg_we    = 1'b0;
    logic [LB_W-1:0] cfg_data  = '0;

    // Words waiting to be sent and characters waiting to be received
    in_word_t  pending_words[$];
    out_word_t expected_chars[$];

    // Predictor state
    logic [BYTE_W-1:0] line_store[LINE_CAP];
    int                held_count;
    logic [LB_W-1:0]   line_bytes_cfg;

    // Idling control, set per phase
    int gap_odds;
    int stall_odds;
    int send_gap;
    int stall_left;

    int        errors;
    int        cycle_count;
    out_word_t want_char;

    uuencode_line_encoder u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data)
    );

    always #1 clk = ~clk;

    // Map a six-bit value to its line character
    function automatic logic [CHAR_W-1:0] printable_of(input logic [SEXT_W-1:0] v);
        logic [CHAR_W-1:0] c;
        c = CHAR_SPACE + {1'b0, v};
        if (c == CHAR_SPACE)
            c = CHAR_BACKTICK;
        return c;
    endfunction

    task automatic push_char(input logic [CHAR_W-1:0] c, input logic is_last);
        out_word_t w;
        w.out_char = c;
        w.last     = is_last;
        expected_chars.push_back(w);
    endtask

    // Encode the held bytes as one line and empty the buffer
    task automatic emit_encoded_line();
        int                g;
        logic [BYTE_W-1:0] b0;
        logic [BYTE_W-1:0] b1;
        logic [BYTE_W-1:0] b2;
        push_char(printable_of(held_count[SEXT_W-1:0]), 1'b0);
        for (g = 0; g < held_count; g += 3)
        begin
            b0 = line_store[g];
            b1 = (g + 1 < held_count) ? line_store[g + 1] : '0;
            b2 = (g + 2 < held_count) ? line_store[g + 2] : '0;
            push_char(printable_of(b0[7:2]), 1'b0);
            push_char(printable_of({b0[1:0], b1[7:4]}), 1'b0);
            push_char(printable_of({b1[3:0], b2[7:6]}), 1'b0);
            push_char(printable_of(b2[5:0]), 1'b0);
        end
        push_char(CHAR_NL, 1'b1);
        held_count = 0;
    endtask

    // Advance the line predictor by one accepted word
    task automatic predict_line_chars(input in_word_t w);
        int limit;
        limit = int'(line_bytes_cfg);
        if (limit == 0)
            limit = 1;
        if (limit > LINE_CAP)
            limit = LINE_CAP;
        if (w.mode == MODE_END)
        begin
            if (held_count != 0)
                emit_encoded_line();
        end
        else
        begin
            if (held_count < LINE_CAP)
            begin
                line_store[held_count] = w.data_byte;
                held_count++;
            end
            if (held_count >= limit)
                emit_encoded_line();
        end
    endtask

    task automatic queue_word(input logic m, input logic [BYTE_W-1:0] b);
        in_word_t w;
        w.mode      = m;
        w.data_byte = b;
        pending_words.push_back(w);
    endtask

    // Random words; end marks come one in end_one_in, never when zero
    task automatic queue_random(input int count, input int end_one_in);
        int k;
        for (k = 0; k < count; k++)
        begin
            if (end_one_in != 0 && $urandom_range(0, end_one_in - 1) == 0)
                queue_word(MODE_END, BYTE_W'($urandom_range(0, 255)));
            else
                queue_word(MODE_DATA, BYTE_W'($urandom_range(0, 255)));
        end
    endtask

    // Hold until every word is sent and every character has come back
    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_words.size() != 0 || in_valid || expected_chars.size() != 0);
    endtask

    task automatic set_idling(input logic quiet);
        gap_odds   = quiet ? 0 : $urandom_range(0, 3);
        stall_odds = quiet ? 0 : $urandom_range(0, 3);
    endtask

    // Write the bytes-per-line register once the encoder is idle
    task automatic write_line_bytes(input logic [LB_W-1:0] v);
        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge clk);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we         <= 1'b0;
        line_bytes_cfg  = v;
        @(negedge clk);
    endtask

    // Input side: present the next word, with random gaps between words
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_word  <= '0;
            send_gap  = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                predict_line_chars(in_word);
            if (!in_valid || !in_stall)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (pending_words.size() != 0)
                begin
                    in_word  <= pending_words.pop_front();
                    in_valid <= 1'b1;
                    if (gap_odds != 0 && $urandom_range(0, gap_odds * 3) == 0)
                        send_gap = $urandom_range(1, 9);
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Output side: check each accepted character and stall in random bursts
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_chars.size() == 0)
                begin
                    $display("%0t: unexpected char: expected none, actual char %0d last %0b",
                             $time, out_word.out_char, out_word.last);
                    errors++;
                end
                else
                begin
                    want_char = expected_chars.pop_front();
                    if (out_word.out_char !== want_char.out_char)
                    begin
                        $display("%0t: out_char mismatch: expected %0d, actual %0d",
                                 $time, want_char.out_char, out_word.out_char);
                        errors++;
                    end
                    if (out_word.last !== want_char.last)
                    begin
                        $display("%0t: last mismatch: expected %0b, actual %0b",
                                 $time, want_char.last, out_word.last);
                        errors++;
                    end
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else if (stall_odds != 0 && $urandom_range(0, stall_odds * 3) == 0)
            begin
                stall_left = $urandom_range(1, 9) - 1;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    // Stop a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        int ph;
        errors         = 0;
        cycle_count    = 0;
        held_count     = 0;
        line_bytes_cfg = LINE_BYTES_RESET;
        gap_odds       = 1;
        stall_odds     = 1;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // End mark on an empty line, then a four-byte line with extreme bytes
        queue_word(MODE_END, 8'hFF);
        queue_word(MODE_DATA, 8'h00);
        queue_word(MODE_DATA, 8'hFF);
        queue_word(MODE_DATA, 8'h80);
        queue_word(MODE_DATA, 8'h7F);
        queue_word(MODE_END, 8'h00);
        queue_word(MODE_END, 8'h5A);
        // One- and two-byte lines, padded with zeros
        queue_word(MODE_DATA, 8'h55);
        queue_word(MODE_END, 8'hA5);
        queue_word(MODE_DATA, 8'hAA);
        queue_word(MODE_DATA, 8'h01);
        queue_word(MODE_END, 8'h00);
        // Fill seven bytes, then drop the line length below the fill
        queue_word(MODE_DATA, 8'h01);
        queue_word(MODE_DATA, 8'h02);
        queue_word(MODE_DATA, 8'h04);
        queue_word(MODE_DATA, 8'h08);
        queue_word(MODE_DATA, 8'h10);
        queue_word(MODE_DATA, 8'h20);
        queue_word(MODE_DATA, 8'h40);
        write_line_bytes(6'd2);
        queue_word(MODE_DATA, 8'hFE);
        // Zero line length acts as one byte per line
        write_line_bytes(6'd0);
        queue_word(MODE_DATA, 8'h3F);
        queue_word(MODE_DATA, 8'hC0);

        // Oversized line length caps at the buffer depth
        write_line_bytes(6'd63);
        set_idling(1'b0);
        queue_random(50, 0);
        queue_random(20, 10);

        write_line_bytes(6'd1);
        set_idling(1'b0);
        queue_random(30, 4);

        write_line_bytes(6'd3);
        set_idling(1'b0);
        queue_random(40, 6);

        write_line_bytes(6'd45);
        set_idling(1'b0);
        queue_random(60, 20);

        for (ph = 0; ph < 4; ph++)
        begin
            write_line_bytes(LB_W'($urandom_range(0, 63)));
            set_idling(1'b0);
            queue_random(30, 8);
        end

        write_line_bytes(6'd0);
        set_idling(1'b0);
        queue_random(20, 5);

        // Closing stretch with no gaps and no stalls
        set_idling(1'b1);
        write_line_bytes(LB_W'($urandom_range(0, 63)));
        queue_random(85, 10);
        queue_word(MODE_END, BYTE_W'($urandom_range(0, 255)));

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
